[sv/rtch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types, the multiply sequence table and saturation helpers for the
// closest-hit ray/triangle block.
// ----------------------------------------------------------------------------
package rtch_pkg;

  localparam int NUM_STEPS      = 27;
  localparam int STEP_BITS      = 5;
  localparam int ACC_BITS       = 66;
  localparam int CFG_IDX_BITS   = 3;

  typedef logic [STEP_BITS-1:0] step_idx_t;

  localparam step_idx_t STEP_PRE_LAST   = 5'd8;
  localparam step_idx_t STEP_POST_FIRST = 5'd9;
  localparam step_idx_t STEP_POST_LAST  = 5'd26;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MISS     = 3'd6;

  typedef enum logic [4:0] {
    OP_DX, OP_DY, OP_DZ,
    OP_E1X, OP_E1Y, OP_E1Z,
    OP_E2X, OP_E2Y, OP_E2Z,
    OP_SX, OP_SY, OP_SZ,
    OP_HX, OP_HY, OP_HZ,
    OP_QX, OP_QY, OP_QZ,
    OP_DA, OP_DB, OP_F
  } opsel_e;

  typedef enum logic [1:0] {
    ACC_FIRST,
    ACC_ADD,
    ACC_SUB
  } accop_e;

  typedef enum logic [3:0] {
    DST_HX, DST_HY, DST_HZ,
    DST_QX, DST_QY, DST_QZ,
    DST_DET, DST_DA, DST_DB,
    DST_U, DST_V, DST_T
  } dst_e;

  typedef struct packed {
    opsel_e a;
    opsel_e b;
    accop_e acc;
    logic   wr;
    dst_e   dst;
  } step_t;

  typedef struct packed {
    logic      load;
    logic      issue;
    step_idx_t step;
    logic      div_start;
    logic      judge;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
    logic last;
    logic out_free;
  } sts_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PRE   = 10'b0000000010,
    S_DWAIT = 10'b0000000100,
    S_DCHK  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_POST  = 10'b0000100000,
    S_PWAIT = 10'b0001000000,
    S_JUDGE = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_e;

  // h = dir x e2, det = e1.h, then s.h, q = s x e1, u, dir.q, e2.q, v, t
  function automatic step_t step_rom(input step_idx_t idx);
    step_t s;
    s = '{a: OP_DX, b: OP_DX, acc: ACC_FIRST, wr: 1'b0, dst: DST_HX};
    case (idx)
      5'd0:  s = '{OP_DY,  OP_E2Z, ACC_FIRST, 1'b0, DST_HX};
      5'd1:  s = '{OP_DZ,  OP_E2Y, ACC_SUB,   1'b1, DST_HX};
      5'd2:  s = '{OP_DZ,  OP_E2X, ACC_FIRST, 1'b0, DST_HY};
      5'd3:  s = '{OP_DX,  OP_E2Z, ACC_SUB,   1'b1, DST_HY};
      5'd4:  s = '{OP_DX,  OP_E2Y, ACC_FIRST, 1'b0, DST_HZ};
      5'd5:  s = '{OP_DY,  OP_E2X, ACC_SUB,   1'b1, DST_HZ};
      5'd6:  s = '{OP_E1X, OP_HX,  ACC_FIRST, 1'b0, DST_DET};
      5'd7:  s = '{OP_E1Y, OP_HY,  ACC_ADD,   1'b0, DST_DET};
      5'd8:  s = '{OP_E1Z, OP_HZ,  ACC_ADD,   1'b1, DST_DET};
      5'd9:  s = '{OP_SX,  OP_HX,  ACC_FIRST, 1'b0, DST_DA};
      5'd10: s = '{OP_SY,  OP_HY,  ACC_ADD,   1'b0, DST_DA};
      5'd11: s = '{OP_SZ,  OP_HZ,  ACC_ADD,   1'b1, DST_DA};
      5'd12: s = '{OP_SY,  OP_E1Z, ACC_FIRST, 1'b0, DST_QX};
      5'd13: s = '{OP_SZ,  OP_E1Y, ACC_SUB,   1'b1, DST_QX};
      5'd14: s = '{OP_SZ,  OP_E1X, ACC_FIRST, 1'b0, DST_QY};
      5'd15: s = '{OP_SX,  OP_E1Z, ACC_SUB,   1'b1, DST_QY};
      5'd16: s = '{OP_SX,  OP_E1Y, ACC_FIRST, 1'b0, DST_QZ};
      5'd17: s = '{OP_SY,  OP_E1X, ACC_SUB,   1'b1, DST_QZ};
      5'd18: s = '{OP_F,   OP_DA,  ACC_FIRST, 1'b1, DST_U};
      5'd19: s = '{OP_DX,  OP_QX,  ACC_FIRST, 1'b0, DST_DB};
      5'd20: s = '{OP_DY,  OP_QY,  ACC_ADD,   1'b0, DST_DB};
      5'd21: s = '{OP_DZ,  OP_QZ,  ACC_ADD,   1'b1, DST_DB};
      5'd22: s = '{OP_E2X, OP_QX,  ACC_FIRST, 1'b0, DST_DA};
      5'd23: s = '{OP_E2Y, OP_QY,  ACC_ADD,   1'b0, DST_DA};
      5'd24: s = '{OP_E2Z, OP_QZ,  ACC_ADD,   1'b1, DST_DA};
      5'd25: s = '{OP_F,   OP_DB,  ACC_FIRST, 1'b1, DST_V};
      5'd26: s = '{OP_F,   OP_DA,  ACC_FIRST, 1'b1, DST_T};
      default: s = '{OP_DX, OP_DX, ACC_FIRST, 1'b0, DST_HX};
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return d[31:0];
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_BITS-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[ACC_BITS-1:31];
    hi_zeros = ~|x[ACC_BITS-1:31];
    if (!(hi_ones || hi_zeros)) begin
      return x[ACC_BITS-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return x[31:0];
  endfunction

endpackage

[sv/rtch_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtch_div
// Radix-2 restoring divider for f = 2^(2*FRAC_BITS) / det, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtch_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] num_q, num_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   mag_q, mag_d;
  logic          neg_q, neg_d;

  logic [32:0]   trial;
  logic [32:0]   diff;
  logic [63:0]   qext;

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    trial  = {rem_q, num_q[QW-1]};
    diff   = trial - {1'b0, mag_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
      num_d  = {1'b1, {(QW-1){1'b0}}};
      quot_d = '0;
      rem_d  = '0;
      neg_d  = den_i[31];
      mag_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
    end else if (busy_q) begin
      num_d = {num_q[QW-2:0], 1'b0};
      if (!diff[32]) begin
        rem_d  = diff[31:0];
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
  end

  always_comb begin
    qext = 64'(quot_q);
    if (neg_q) begin
      quo_o = (qext > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-qext);
    end else begin
      quo_o = (qext > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(qext);
    end
  end

  assign done_o = fin_q;

endmodule

[sv/rtch_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtch_dp
// Datapath: edge registers, one shared 32x32 multiplier with accumulator,
// reciprocal divider, closest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rtch_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rtch_pkg::cmd_t        cmd_i,
  output rtch_pkg::sts_t        sts_o,
  input  logic signed [31:0]    org_x_i,
  input  logic signed [31:0]    org_y_i,
  input  logic signed [31:0]    org_z_i,
  input  logic signed [31:0]    dir_x_i,
  input  logic signed [31:0]    dir_y_i,
  input  logic signed [31:0]    dir_z_i,
  input  logic [30:0]           miss_i,
  input  logic signed [31:0]    v0_x_i,
  input  logic signed [31:0]    v0_y_i,
  input  logic signed [31:0]    v0_z_i,
  input  logic signed [31:0]    v1_x_i,
  input  logic signed [31:0]    v1_y_i,
  input  logic signed [31:0]    v1_z_i,
  input  logic signed [31:0]    v2_x_i,
  input  logic signed [31:0]    v2_y_i,
  input  logic signed [31:0]    v2_z_i,
  input  logic [INDEX_BITS-1:0] tri_id_i,
  input  logic                  last_tri_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  any_hit_o,
  output logic [30:0]           hit_t_o,
  output logic [16:0]           hit_u_o,
  output logic [16:0]           hit_v_o,
  output logic [INDEX_BITS-1:0] hit_tri_o
);

  localparam int AW = rtch_pkg::ACC_BITS;

  logic signed [31:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q, sx_q, sy_q, sz_q;
  logic signed [31:0] hx_q, hy_q, hz_q, qx_q, qy_q, qz_q;
  logic signed [31:0] det_q, da_q, db_q, f_q, u_q, v_q, t_q;
  logic [INDEX_BITS-1:0] tri_q;
  logic                  last_q;

  rtch_pkg::step_t    step_q;
  logic               s2_q;
  logic signed [63:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_d, p_ext;
  logic signed [31:0] res;
  logic signed [31:0] opa, opb;
  rtch_pkg::step_t    step_cur;

  logic               div_done;
  logic signed [31:0] div_quo;

  logic               hit_seen_q;
  logic signed [31:0] best_t_q;
  logic [16:0]        best_u_q, best_v_q;
  logic [INDEX_BITS-1:0] best_tri_q;

  logic               out_valid_q;
  logic               out_any_q;
  logic [30:0]        out_t_q;
  logic [16:0]        out_u_q, out_v_q;
  logic [INDEX_BITS-1:0] out_tri_q;

  logic signed [33:0] w;
  logic signed [31:0] limit;
  logic               pass;

  function automatic logic signed [31:0] pick(input rtch_pkg::opsel_e sel,
    input logic signed [31:0] dx, input logic signed [31:0] dy,
    input logic signed [31:0] dz, input logic signed [31:0] e1x,
    input logic signed [31:0] e1y, input logic signed [31:0] e1z,
    input logic signed [31:0] e2x, input logic signed [31:0] e2y,
    input logic signed [31:0] e2z, input logic signed [31:0] sx,
    input logic signed [31:0] sy, input logic signed [31:0] sz,
    input logic signed [31:0] hx, input logic signed [31:0] hy,
    input logic signed [31:0] hz, input logic signed [31:0] qx,
    input logic signed [31:0] qy, input logic signed [31:0] qz,
    input logic signed [31:0] da, input logic signed [31:0] db,
    input logic signed [31:0] f);
    logic signed [31:0] r;
    case (sel)
      rtch_pkg::OP_DX:  r = dx;
      rtch_pkg::OP_DY:  r = dy;
      rtch_pkg::OP_DZ:  r = dz;
      rtch_pkg::OP_E1X: r = e1x;
      rtch_pkg::OP_E1Y: r = e1y;
      rtch_pkg::OP_E1Z: r = e1z;
      rtch_pkg::OP_E2X: r = e2x;
      rtch_pkg::OP_E2Y: r = e2y;
      rtch_pkg::OP_E2Z: r = e2z;
      rtch_pkg::OP_SX:  r = sx;
      rtch_pkg::OP_SY:  r = sy;
      rtch_pkg::OP_SZ:  r = sz;
      rtch_pkg::OP_HX:  r = hx;
      rtch_pkg::OP_HY:  r = hy;
      rtch_pkg::OP_HZ:  r = hz;
      rtch_pkg::OP_QX:  r = qx;
      rtch_pkg::OP_QY:  r = qy;
      rtch_pkg::OP_QZ:  r = qz;
      rtch_pkg::OP_DA:  r = da;
      rtch_pkg::OP_DB:  r = db;
      rtch_pkg::OP_F:   r = f;
      default:          r = '0;
    endcase
    return r;
  endfunction

  // edges and origin offset, taken at the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e1x_q  <= rtch_pkg::sat_sub(v1_x_i, v0_x_i);
      e1y_q  <= rtch_pkg::sat_sub(v1_y_i, v0_y_i);
      e1z_q  <= rtch_pkg::sat_sub(v1_z_i, v0_z_i);
      e2x_q  <= rtch_pkg::sat_sub(v2_x_i, v0_x_i);
      e2y_q  <= rtch_pkg::sat_sub(v2_y_i, v0_y_i);
      e2z_q  <= rtch_pkg::sat_sub(v2_z_i, v0_z_i);
      sx_q   <= rtch_pkg::sat_sub(org_x_i, v0_x_i);
      sy_q   <= rtch_pkg::sat_sub(org_y_i, v0_y_i);
      sz_q   <= rtch_pkg::sat_sub(org_z_i, v0_z_i);
      tri_q  <= tri_id_i;
      last_q <= last_tri_i;
    end
  end

  // stage 1: operand select and multiply
  always_comb begin
    step_cur = rtch_pkg::step_rom(cmd_i.step);
    opa = pick(step_cur.a, dir_x_i, dir_y_i, dir_z_i, e1x_q, e1y_q, e1z_q,
               e2x_q, e2y_q, e2z_q, sx_q, sy_q, sz_q, hx_q, hy_q, hz_q,
               qx_q, qy_q, qz_q, da_q, db_q, f_q);
    opb = pick(step_cur.b, dir_x_i, dir_y_i, dir_z_i, e1x_q, e1y_q, e1z_q,
               e2x_q, e2y_q, e2z_q, sx_q, sy_q, sz_q, hx_q, hy_q, hz_q,
               qx_q, qy_q, qz_q, da_q, db_q, f_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
    end else begin
      s2_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= 64'(opa) * 64'(opb);
      step_q <= step_cur;
    end
  end

  // stage 2: scale, accumulate, saturate, write back
  always_comb begin
    p_ext = AW'(prod_q >>> FRAC_BITS);
    case (step_q.acc)
      rtch_pkg::ACC_FIRST: acc_d = p_ext;
      rtch_pkg::ACC_ADD:   acc_d = acc_q + p_ext;
      rtch_pkg::ACC_SUB:   acc_d = acc_q - p_ext;
      default:             acc_d = p_ext;
    endcase
    res = rtch_pkg::sat_acc(acc_d);
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      acc_q <= acc_d;
      if (step_q.wr) begin
        case (step_q.dst)
          rtch_pkg::DST_HX:  hx_q  <= res;
          rtch_pkg::DST_HY:  hy_q  <= res;
          rtch_pkg::DST_HZ:  hz_q  <= res;
          rtch_pkg::DST_QX:  qx_q  <= res;
          rtch_pkg::DST_QY:  qy_q  <= res;
          rtch_pkg::DST_QZ:  qz_q  <= res;
          rtch_pkg::DST_DET: det_q <= res;
          rtch_pkg::DST_DA:  da_q  <= res;
          rtch_pkg::DST_DB:  db_q  <= res;
          rtch_pkg::DST_U:   u_q   <= res;
          rtch_pkg::DST_V:   v_q   <= res;
          rtch_pkg::DST_T:   t_q   <= res;
          default: ;
        endcase
      end
    end
    if (div_done) begin
      f_q <= div_quo;
    end
  end

  rtch_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // hit test against the running best
  always_comb begin
    w     = (34'sd1 <<< FRAC_BITS) - 34'(u_q) - 34'(v_q);
    pass  = (u_q > 0) && (v_q > 0) && (t_q > 0) && (w > 0);
    limit = hit_seen_q ? best_t_q : $signed({1'b0, miss_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q <= 1'b0;
    end else if (cmd_i.emit) begin
      hit_seen_q <= 1'b0;
    end else if (cmd_i.judge && pass && (t_q < limit)) begin
      hit_seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.judge && pass && (t_q < limit)) begin
      best_t_q   <= t_q;
      best_u_q   <= u_q[16:0];
      best_v_q   <= v_q[16:0];
      best_tri_q <= tri_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_any_q <= hit_seen_q;
      out_t_q   <= hit_seen_q ? best_t_q[30:0] : miss_i;
      out_u_q   <= hit_seen_q ? best_u_q : '0;
      out_v_q   <= hit_seen_q ? best_v_q : '0;
      out_tri_q <= hit_seen_q ? best_tri_q : '0;
    end
  end

  assign sts_o.det_zero = (det_q == 32'sd0);
  assign sts_o.div_done = div_done;
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign any_hit_o   = out_any_q;
  assign hit_t_o     = out_t_q;
  assign hit_u_o     = out_u_q;
  assign hit_v_o     = out_v_q;
  assign hit_tri_o   = out_tri_q;

endmodule

[sv/rtch_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtch_ctrl
// Sequencer: steps the shared multiplier through the product list, starts the
// reciprocal, runs the hit test and hands a run's result to the output register.
// ----------------------------------------------------------------------------
module rtch_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output rtch_pkg::cmd_t cmd_o,
  input  rtch_pkg::sts_t sts_i
);

  rtch_pkg::state_e    state_q, state_d;
  rtch_pkg::step_idx_t cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.step = cnt_q;
    case (state_q)
      rtch_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = rtch_pkg::S_PRE;
        end
      end
      rtch_pkg::S_PRE: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 5'd1;
        if (cnt_q == rtch_pkg::STEP_PRE_LAST) begin
          state_d = rtch_pkg::S_DWAIT;
        end
      end
      rtch_pkg::S_DWAIT: state_d = rtch_pkg::S_DCHK;
      rtch_pkg::S_DCHK: begin
        if (sts_i.det_zero) begin
          state_d = rtch_pkg::S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = rtch_pkg::S_DIV;
        end
      end
      rtch_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          cnt_d   = rtch_pkg::STEP_POST_FIRST;
          state_d = rtch_pkg::S_POST;
        end
      end
      rtch_pkg::S_POST: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 5'd1;
        if (cnt_q == rtch_pkg::STEP_POST_LAST) begin
          state_d = rtch_pkg::S_PWAIT;
        end
      end
      rtch_pkg::S_PWAIT: state_d = rtch_pkg::S_JUDGE;
      rtch_pkg::S_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = rtch_pkg::S_FIN;
      end
      rtch_pkg::S_FIN: begin
        if (!sts_i.last) begin
          state_d = rtch_pkg::S_IDLE;
        end else begin
          state_d = rtch_pkg::S_HOLD;
        end
      end
      rtch_pkg::S_HOLD: begin
        // wait for the result register to drain
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = rtch_pkg::S_IDLE;
        end
      end
      default: state_d = rtch_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == rtch_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtch_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_issue_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (state_q == rtch_pkg::S_PRE || state_q == rtch_pkg::S_POST))
    else $error("multiplier issued outside a product sequence");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == rtch_pkg::S_DIV))
    else $error("divider finished while not awaited");
  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == rtch_pkg::S_IDLE))
    else $error("no return to idle after result");
  a_load_starts_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == rtch_pkg::S_PRE && cnt_q == '0))
    else $error("accepted triangle did not start the product sequence");
`endif

endmodule

[sv/ray_triangle_closest_hit_top.sv]
`timescale 1ns / 1ps
// Closest-hit ray/triangle test in signed fixed point. Write the ray origin,
// direction and miss distance first, then stream triangles; the closest hit
// of a run comes out as one result beat on the triangle that carries last_tri.
// From its input beat to the next ready, a triangle runs 27 products through
// one shared multiplier and a one-bit-per-cycle restoring divider for the
// determinant reciprocal. The triangle that carries last_tri also passes the
// hold state, and holds longer while the previous result still waits on the
// output. A triangle with a zero determinant skips the divider, the remaining
// products and the hit test. A new triangle is taken while a finished result
// still waits on the output.
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top
// Configuration registers, sequencer and datapath of the closest-hit block.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    v0_x_i,
  input  logic signed [31:0]    v0_y_i,
  input  logic signed [31:0]    v0_z_i,
  input  logic signed [31:0]    v1_x_i,
  input  logic signed [31:0]    v1_y_i,
  input  logic signed [31:0]    v1_z_i,
  input  logic signed [31:0]    v2_x_i,
  input  logic signed [31:0]    v2_y_i,
  input  logic signed [31:0]    v2_z_i,
  input  logic [INDEX_BITS-1:0] tri_id_i,
  input  logic                  last_tri_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  any_hit_o,
  output logic [30:0]           hit_t_o,
  output logic [16:0]           hit_u_o,
  output logic [16:0]           hit_v_o,
  output logic [INDEX_BITS-1:0] hit_tri_o
);

  logic signed [31:0] org_x_q, org_y_q, org_z_q, dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        miss_q;
  rtch_pkg::cmd_t     cmd;
  rtch_pkg::sts_t     sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= 32'sd1 <<< FRAC_BITS;
      dir_z_q <= '0;
      miss_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtch_pkg::CFG_ORIGIN_X: org_x_q <= cfg_wdata_i;
        rtch_pkg::CFG_ORIGIN_Y: org_y_q <= cfg_wdata_i;
        rtch_pkg::CFG_ORIGIN_Z: org_z_q <= cfg_wdata_i;
        rtch_pkg::CFG_DIR_X:    dir_x_q <= cfg_wdata_i;
        rtch_pkg::CFG_DIR_Y:    dir_y_q <= cfg_wdata_i;
        rtch_pkg::CFG_DIR_Z:    dir_z_q <= cfg_wdata_i;
        rtch_pkg::CFG_MISS:     miss_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  rtch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rtch_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .org_x_i     (org_x_q),
    .org_y_i     (org_y_q),
    .org_z_i     (org_z_q),
    .dir_x_i     (dir_x_q),
    .dir_y_i     (dir_y_q),
    .dir_z_i     (dir_z_q),
    .miss_i      (miss_q),
    .v0_x_i      (v0_x_i),
    .v0_y_i      (v0_y_i),
    .v0_z_i      (v0_z_i),
    .v1_x_i      (v1_x_i),
    .v1_y_i      (v1_y_i),
    .v1_z_i      (v1_z_i),
    .v2_x_i      (v2_x_i),
    .v2_y_i      (v2_y_i),
    .v2_z_i      (v2_z_i),
    .tri_id_i    (tri_id_i),
    .last_tri_i  (last_tri_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .any_hit_o   (any_hit_o),
    .hit_t_o     (hit_t_o),
    .hit_u_o     (hit_u_o),
    .hit_v_o     (hit_v_o),
    .hit_tri_o   (hit_tri_o)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Closest-hit ray/triangle check: triangles stream in under random gaps and
// back-pressure, a fixed-point intersection predictor tracks the closest hit
// per run, and every result beat is compared with the oldest predicted hit.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC = 16;

  typedef struct {
    logic signed [31:0] vtx[9];
    logic [23:0]        id;
    logic               last;
  } tri_t;

  typedef struct {
    logic        any_hit;
    logic [30:0] t;
    logic [16:0] u;
    logic [16:0] v;
    logic [23:0] id;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] vin[9];
  logic [23:0] tri_id_i = '0;
  logic last_tri_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic any_hit_o;
  logic [30:0] hit_t_o;
  logic [16:0] hit_u_o, hit_v_o;
  logic [23:0] hit_tri_o;

  initial foreach (vin[k]) vin[k] = '0;

  ray_triangle_closest_hit_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .tri_id_i, .last_tri_i,
    .out_valid_o, .out_ready_i,
    .any_hit_o, .hit_t_o, .hit_u_o, .hit_v_o, .hit_tri_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  longint ray_org[3], ray_dir[3], miss_dist, best_t;
  logic [16:0] best_u, best_v;
  logic [23:0] best_id;
  bit hit_seen;

  tri_t pending_tris[$];
  hit_t expected_hits[$];
  int errors = 0;
  int tris_sent = 0;
  int hold_off = 0;
  bit stim_done = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = sat32(mulq(a[1], b[2]) - mulq(a[2], b[1]));
    r[1] = sat32(mulq(a[2], b[0]) - mulq(a[0], b[2]));
    r[2] = sat32(mulq(a[0], b[1]) - mulq(a[1], b[0]));
  endfunction

  function automatic longint dot(input longint a[3], input longint b[3]);
    return sat32(mulq(a[0], b[0]) + mulq(a[1], b[1]) + mulq(a[2], b[2]));
  endfunction

  function automatic void clear_best();
    best_t = miss_dist;
    best_u = '0;
    best_v = '0;
    best_id = '0;
    hit_seen = 0;
  endfunction

  function automatic void predict_tri(tri_t tr);
    longint p0[3], e1[3], e2[3], h[3], s[3], q[3];
    longint det, f, u, v, t, lim;
    hit_t r;
    for (int k = 0; k < 3; k++) begin
      p0[k] = tr.vtx[k];
      e1[k] = sat32(longint'(tr.vtx[3+k]) - p0[k]);
      e2[k] = sat32(longint'(tr.vtx[6+k]) - p0[k]);
      s[k]  = sat32(ray_org[k] - p0[k]);
    end
    cross3(ray_dir, e2, h);
    det = dot(e1, h);
    if (det != 0) begin
      f = sat32((64'sd1 << (2 * FRAC)) / det);
      u = sat32(mulq(f, dot(s, h)));
      cross3(s, e1, q);
      v = sat32(mulq(f, dot(ray_dir, q)));
      t = sat32(mulq(f, dot(e2, q)));
      if (u > 0 && v > 0 && t > 0 && (64'sd65536 - u - v) > 0) begin
        lim = hit_seen ? best_t : miss_dist;
        if (t < lim) begin
          best_t = t;
          best_u = u[16:0];
          best_v = v[16:0];
          best_id = tr.id;
          hit_seen = 1;
        end
      end
    end
    if (tr.last) begin
      r.any_hit = hit_seen;
      r.t  = hit_seen ? best_t[30:0] : miss_dist[30:0];
      r.u  = best_u;
      r.v  = best_v;
      r.id = best_id;
      expected_hits.push_back(r);
      clear_best();
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    tri_t tr;
    if (in_valid_i && in_ready_o) begin
      predict_tri(pending_tris.pop_front());
      tris_sent++;
    end
    if (in_valid_i && !in_ready_o) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid_i <= 1'b0;
    end else if ((in_valid_i && in_ready_o ? pending_tris.size() > 0
                  : pending_tris.size() > 0) && rst_ni) begin
      tr = pending_tris[0];
      foreach (vin[k]) vin[k] <= tr.vtx[k];
      tri_id_i <= tr.id;
      last_tri_i <= tr.last;
      in_valid_i <= 1'b1;
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // long receiver stall, counted down on its own
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk_i) begin
    hit_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        report("unexpected beat", hit_tri_o, 0);
      end else begin
        w = expected_hits.pop_front();
        if (any_hit_o !== w.any_hit) report("any_hit", any_hit_o, w.any_hit);
        if (hit_t_o !== w.t) report("hit_t", hit_t_o, w.t);
        if (hit_u_o !== w.u) report("hit_u", hit_u_o, w.u);
        if (hit_v_o !== w.v) report("hit_v", hit_v_o, w.v);
        if (hit_tri_o !== w.id) report("hit_tri", hit_tri_o, w.id);
      end
      out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
    endcase
  endfunction

  // triangle around the ray near the current direction, with random depth
  function automatic tri_t aimed_tri(bit last);
    tri_t tr;
    longint c[3];
    int depth;
    depth = $urandom_range(1, 40);
    for (int k = 0; k < 3; k++) c[k] = ray_org[k] + ray_dir[k] * depth;
    for (int n = 0; n < 3; n++)
      for (int k = 0; k < 3; k++)
        tr.vtx[3*n+k] = 32'(sat32(c[k] + $signed($urandom_range(0, 6 << FRAC))
                                  - (3 << FRAC)));
    tr.id = 24'($urandom());
    tr.last = last;
    return tr;
  endfunction

  function automatic tri_t noise_tri(bit last);
    tri_t tr;
    foreach (tr.vtx[k]) tr.vtx[k] = rnd_coord();
    tr.id = 24'($urandom());
    tr.last = last;
    return tr;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rtch_pkg::CFG_ORIGIN_X: ray_org[0] = longint'($signed(val));
      rtch_pkg::CFG_ORIGIN_Y: ray_org[1] = longint'($signed(val));
      rtch_pkg::CFG_ORIGIN_Z: ray_org[2] = longint'($signed(val));
      rtch_pkg::CFG_DIR_X:    ray_dir[0] = longint'($signed(val));
      rtch_pkg::CFG_DIR_Y:    ray_dir[1] = longint'($signed(val));
      rtch_pkg::CFG_DIR_Z:    ray_dir[2] = longint'($signed(val));
      rtch_pkg::CFG_MISS:     miss_dist = longint'(val[30:0]);
      default: ;
    endcase
    best_t = hit_seen ? best_t : miss_dist;
  endtask

  task automatic drain();
    while (pending_tris.size() > 0 || in_valid_i || expected_hits.size() > 0)
      @(posedge clk_i);
    // a non-last triangle may still be in flight
    repeat (120) @(posedge clk_i);
  endtask

  initial begin
    tri_t tr;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 65536, 0};
    miss_dist = 64'h7fff_ffff;
    clear_best();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: default ray along +y
    tr.vtx = '{-65536, 5 << FRAC, -65536, 3 << FRAC, 5 << FRAC, -65536,
               -65536, 5 << FRAC, 3 << FRAC};
    tr.id = 24'h00_0001; tr.last = 0; pending_tris.push_back(tr);
    tr.vtx = '{-65536, 2 << FRAC, -65536, 3 << FRAC, 2 << FRAC, -65536,
               -65536, 2 << FRAC, 3 << FRAC};
    tr.id = 24'hff_ffff; tr.last = 0; pending_tris.push_back(tr);
    // same distance again: tie keeps the earlier one
    tr.id = 24'h12_3456; tr.last = 1; pending_tris.push_back(tr);
    // degenerate, zero determinant
    tr.vtx = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; tr.id = 24'd7; tr.last = 1;
    pending_tris.push_back(tr);
    // behind the ray
    tr.vtx = '{-65536, -(2 << FRAC), -65536, 3 << FRAC, -(2 << FRAC), -65536,
               -65536, -(2 << FRAC), 3 << FRAC};
    tr.id = 24'd9; tr.last = 1; pending_tris.push_back(tr);
    tr.vtx = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh8000_0000};
    tr.id = 24'hff_ffff; tr.last = 1; pending_tris.push_back(tr);
    drain();

    // miss distance below the hit distance: pass is not a hit
    write_reg(rtch_pkg::CFG_MISS, 32'd65536);
    tr.vtx = '{-65536, 2 << FRAC, -65536, 3 << FRAC, 2 << FRAC, -65536,
               -65536, 2 << FRAC, 3 << FRAC};
    tr.id = 24'd3; tr.last = 1; pending_tris.push_back(tr);
    drain();
    write_reg(rtch_pkg::CFG_MISS, 32'd0);
    write_reg(rtch_pkg::CFG_MISS, 32'h7fff_ffff);
    pending_tris.push_back(tr);
    for (int k = 0; k < 6; k++) pending_tris.push_back(noise_tri(k == 5));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rtch_pkg::CFG_ORIGIN_X,
                (ph == 1) ? 32'h8000_0000 : $urandom_range(0, 8 << FRAC));
      write_reg(rtch_pkg::CFG_ORIGIN_Y,
                (ph == 1) ? 32'h7fff_ffff : $urandom_range(0, 8 << FRAC));
      write_reg(rtch_pkg::CFG_ORIGIN_Z, $urandom());
      if (ph % 3 == 0) write_reg(rtch_pkg::CFG_ORIGIN_Z, $urandom_range(0, 4 << FRAC));
      write_reg(rtch_pkg::CFG_DIR_X, $signed($urandom_range(0, 2 << FRAC)) - 65536);
      write_reg(rtch_pkg::CFG_DIR_Y, (ph == 2) ? 32'h8000_0000 : 32'd65536);
      write_reg(rtch_pkg::CFG_DIR_Z, (ph == 3) ? 32'h7fff_ffff
                : $signed($urandom_range(0, 2 << FRAC)) - 65536);
      write_reg(rtch_pkg::CFG_MISS, (ph == 4) ? 32'd0 : (ph == 5) ? 32'h7fff_ffff
                : $urandom_range(1 << FRAC, 64 << FRAC));
      if (ph == 6) hold_off = 600;
      for (int n = 0; n < 110; n++) begin
        bit last;
        last = ($urandom_range(0, 4) == 0) || n == 109;
        pending_tris.push_back(($urandom_range(0, 4) == 0) ? noise_tri(last)
                               : aimed_tri(last));
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 400_000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[filelist.f]
sv/rtch_pkg.sv
sv/rtch_div.sv
sv/rtch_dp.sv
sv/rtch_ctrl.sv
sv/ray_triangle_closest_hit_top.sv
tb/sv/tb.sv
